// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that sample on clk and stay quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VNF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define VNF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/vnfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vnfc_pkg
// Shared types and codes of the voxel face culler and its table cells.
// ----------------------------------------------------------------------------
package vnfc_pkg;

	localparam int NUM_FACES = 6;
	localparam logic [NUM_FACES-1:0] ALL_FACES = '1;

	// Request kinds carried in the input tuser.
	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_CULL   = 2'd3
	} req_t;

	// Result status carried in the output tuser.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		C_IDLE   = 3'd0,
		C_PROBE  = 3'd1,
		C_WRITE  = 3'd2,
		C_SHIFT  = 3'd3,
		C_CLEAR  = 3'd4,
		C_ROTATE = 3'd5,
		C_APPLY  = 3'd6
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     acc;   // fold broadcast neighbor hits into the handed mask
	} cell_ctrl_t;

endpackage

// ----- design/vnfc_cell.sv -----
// ----------------------------------------------------------------------------
// vnfc_cell
// One table entry: position, visible faces and a neighbor accumulator.
// ----------------------------------------------------------------------------
module vnfc_cell #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  vnfc_pkg::cell_ctrl_t          ctrl,
	input  logic                          sel,
	input  logic [3*COORD_BITS-1:0]       bcast_pos,
	input  logic [3*COORD_BITS-1:0]       nxt_pos,
	input  logic [vnfc_pkg::NUM_FACES-1:0] nxt_vis,
	input  logic [vnfc_pkg::NUM_FACES-1:0] nxt_nm,
	output logic [3*COORD_BITS-1:0]       pos,
	output logic [vnfc_pkg::NUM_FACES-1:0] vis,
	output logic [vnfc_pkg::NUM_FACES-1:0] nm,
	output logic                          eq,
	output logic [vnfc_pkg::NUM_FACES-1:0] qf
);
	import vnfc_pkg::*;

	localparam int CW = COORD_BITS;
	localparam logic signed [CW:0] D_ONE  = (CW+1)'(1);
	localparam logic signed [CW:0] D_MONE = -D_ONE;

	logic [3*CW-1:0]      pos_q;
	logic [NUM_FACES-1:0] vis_q;
	logic [NUM_FACES-1:0] nm_q;
	logic                 eq_q;
	logic [NUM_FACES-1:0] qf_q;
	logic [NUM_FACES-1:0] hit;

	// Faces of b touched by a: a minus b is plus or minus one on a single axis, zero on the rest.
	function automatic logic [NUM_FACES-1:0] face_flags(input logic [3*CW-1:0] a,
			input logic [3*CW-1:0] b);
		logic signed [CW:0]   d [3];
		logic [2:0]           z;
		logic [NUM_FACES-1:0] f;
		for (int k = 0; k < 3; k++) begin
			d[k] = $signed({a[k*CW+CW-1], a[k*CW +: CW]})
				- $signed({b[k*CW+CW-1], b[k*CW +: CW]});
			z[k] = (d[k] == '0);
		end
		f = '0;
		for (int k = 0; k < 3; k++) begin
			if (z[(k+1)%3] && z[(k+2)%3]) begin
				if (d[k] == D_ONE)
					f[2*k] = 1'b1;
				else if (d[k] == D_MONE)
					f[2*k+1] = 1'b1;
			end
		end
		return f;
	endfunction

	// A query looks at this entry relative to the probe; the cull walk looks at
	// the circulating entry relative to this one.
	always_comb begin
		if (ctrl.op == C_PROBE)
			hit = face_flags(pos_q, bcast_pos);
		else
			hit = face_flags(bcast_pos, pos_q);
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			C_PROBE: begin
				eq_q <= (pos_q == bcast_pos);
				qf_q <= hit;
			end
			C_WRITE: begin
				if (sel) begin
					pos_q <= bcast_pos;
					vis_q <= ALL_FACES;
				end
			end
			C_SHIFT: begin
				if (sel) begin
					pos_q <= nxt_pos;
					vis_q <= nxt_vis;
					nm_q  <= nxt_nm;
				end
			end
			C_CLEAR: begin
				nm_q <= '0;
			end
			C_ROTATE: begin
				pos_q <= nxt_pos;
				vis_q <= nxt_vis;
				nm_q  <= nxt_nm;
			end
			C_APPLY: begin
				vis_q <= vis_q & ~nm_q;
			end
			default: begin
			end
		endcase
	end

	assign pos = pos_q;
	assign vis = vis_q;
	assign nm  = nm_q | (ctrl.acc ? hit : '0);
	assign eq  = eq_q;
	assign qf  = qf_q;

endmodule

// ----- design/voxel_neighbor_face_culler.sv -----
// ----------------------------------------------------------------------------
// voxel_neighbor_face_culler
// Table of cube positions with face visibility, kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage. Each input item on s_axis carries a request kind in tuser and a cube
// position in tdata. Add appends the cube with all faces visible, remove
// deletes the first equal entry and closes the gap, query reports which of the
// six face-adjacent cells are occupied, and cull clears touching faces on every
// entry and then streams all entries out in table order, tlast on the final one.
// Every other request, and a cull on an empty table, gives exactly one result item, always with tlast set.
// An add passes through its write state, a remove or query through a probe
// and an evaluate state; the result state then loads the output register once
// it is free and returns the block to idle. A cull clears the neighbor masks,
// rotates the chain once to gather neighbor hits, applies them and rotates
// once more to emit, one cell step per cycle unless the receiver stalls it.
// The block takes one item at a time; s_axis_tready is high while idle, which
// includes the time a finished result still waits in the output register.
// Reset clears the entry count, so the table starts empty; stored positions
// beyond the count never reach a result. When the receiver stalls, the
// output register holds its item and a cull simply pauses its emit rotation.
module voxel_neighbor_face_culler #(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_x[15:0], out_y[31:16], out_z[47:32],
	                                    // neighbour_mask[53:48], visible_mask[59:54], zero
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	output logic        m_axis_tlast    // last
);
	import vnfc_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int IW    = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LV    = $clog2(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_PROBE,
		S_EVAL,
		S_CLR,
		S_ACC,
		S_APPLY,
		S_EMIT,
		S_DONE
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [3*CW-1:0]      pos_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     step_q;
	status_t              res_status_q;
	logic [NUM_FACES-1:0] res_nm_q;
	logic [NUM_FACES-1:0] res_vis_q;

	logic [3*CW-1:0]      cell_pos [TABLE_DEPTH];
	logic [NUM_FACES-1:0] cell_vis [TABLE_DEPTH];
	logic [NUM_FACES-1:0] cell_nm  [TABLE_DEPTH];
	logic [NUM_FACES-1:0] cell_qf  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_eq;
	logic [TABLE_DEPTH-1:0] valid;
	logic [TABLE_DEPTH-1:0] eq_v;
	logic [TABLE_DEPTH-1:0] pre [LV+1];
	logic [TABLE_DEPTH-1:0] sel;
	logic                 found;
	logic [NUM_FACES-1:0] qf_or;
	logic                 full;
	logic                 out_free;
	logic                 out_load;
	logic                 emit_adv;
	logic                 step_last;
	logic [3*CW-1:0]      in_pos;
	logic [3*CW-1:0]      bcast;
	cell_ctrl_t           ctrl;

	function automatic logic [15:0] to_out(input logic [CW-1:0] v);
		return 16'($signed(v));
	endfunction

	// Input coordinates keep their low IW bits as a signed value.
	assign in_pos = {CW'($signed(s_axis_tdata[32 +: IW])),
		CW'($signed(s_axis_tdata[16 +: IW])),
		CW'($signed(s_axis_tdata[0 +: IW]))};

	assign s_axis_tready = (state_q == S_IDLE);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign step_last = (step_q == CNT_W'(TABLE_DEPTH - 1));
	// Past the last live entry the rotation runs on without emitting.
	assign emit_adv  = (step_q >= count_q) || out_free;
	// The output register takes a new item in this cycle.
	assign out_load  = (state_q == S_DONE && out_free) ||
		(state_q == S_EMIT && emit_adv && step_q < count_q);

	// Entries below the count are live; only they take part in a lookup.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			valid[i] = (CNT_W'(i) < count_q);
	end

	assign eq_v  = cell_eq & valid;
	assign found = |eq_v;

	always_comb begin
		qf_or = '0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (valid[i])
				qf_or = qf_or | cell_qf[i];
	end

	// Prefix OR of the match vector: every cell at or above the first match
	// shifts down by one, which deletes that match and closes the gap.
	always_comb begin
		pre[0] = eq_v;
		for (int l = 0; l < LV; l++) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (i >= (1 << l))
					pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
				else
					pre[l+1][i] = pre[l][i];
			end
		end
	end

	always_comb begin
		ctrl  = '{op: C_IDLE, acc: 1'b0};
		sel   = '0;
		bcast = pos_q;
		case (state_q)
			S_ADD: begin
				if (!full)
					ctrl.op = C_WRITE;
				for (int i = 0; i < TABLE_DEPTH; i++)
					sel[i] = (CNT_W'(i) == count_q);
			end
			S_PROBE: begin
				ctrl.op = C_PROBE;
			end
			S_EVAL: begin
				if (req_q == REQ_REMOVE && found)
					ctrl.op = C_SHIFT;
				sel = pre[LV];
			end
			S_CLR: begin
				ctrl.op = C_CLEAR;
			end
			S_ACC: begin
				// The entry at the head of the chain is shown to every cell.
				ctrl.op  = C_ROTATE;
				ctrl.acc = (step_q < count_q);
				bcast    = cell_pos[0];
			end
			S_APPLY: begin
				ctrl.op = C_APPLY;
			end
			S_EMIT: begin
				if (emit_adv)
					ctrl.op = C_ROTATE;
			end
			default: begin
			end
		endcase
	end

	// The chain closes on itself so that a full rotation restores the order.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		localparam int NX = (g + 1) % TABLE_DEPTH;
		vnfc_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.sel      (sel[g]),
			.bcast_pos(bcast),
			.nxt_pos  (cell_pos[NX]),
			.nxt_vis  (cell_vis[NX]),
			.nxt_nm   (cell_nm[NX]),
			.pos      (cell_pos[g]),
			.vis      (cell_vis[g]),
			.nm       (cell_nm[g]),
			.eq       (cell_eq[g]),
			.qf       (cell_qf[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= REQ_ADD;
			pos_q         <= '0;
			count_q       <= '0;
			step_q        <= '0;
			res_status_q  <= ST_OK;
			res_nm_q      <= '0;
			res_vis_q     <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (out_load)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q <= req_t'(s_axis_tuser);
						// A cull on an empty table reports the origin.
						pos_q <= (req_t'(s_axis_tuser) == REQ_CULL) ? '0 : in_pos;
						res_nm_q  <= '0;
						res_vis_q <= '0;
						case (req_t'(s_axis_tuser))
							REQ_ADD: state_q <= S_ADD;
							REQ_REMOVE, REQ_QUERY: state_q <= S_PROBE;
							REQ_CULL: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_CLR;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD: begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_OK;
						res_vis_q    <= ALL_FACES;
						count_q      <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_PROBE: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (req_q == REQ_QUERY) begin
						res_status_q <= ST_OK;
						res_nm_q     <= qf_or;
					end else if (found) begin
						res_status_q <= ST_OK;
						count_q      <= count_q - 1'b1;
					end else begin
						res_status_q <= ST_NOT_FOUND;
					end
					state_q <= S_DONE;
				end
				S_CLR: begin
					step_q  <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (step_last) begin
						step_q  <= '0;
						state_q <= S_APPLY;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_APPLY: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_adv) begin
						if (step_q < count_q) begin
							m_axis_tuser  <= ST_OK;
							m_axis_tlast  <= (step_q == count_q - 1'b1);
							m_axis_tdata  <= {4'b0, cell_vis[0], cell_nm[0],
								to_out(cell_pos[0][2*CW +: CW]),
								to_out(cell_pos[0][CW +: CW]),
								to_out(cell_pos[0][0 +: CW])};
						end
						if (step_last) begin
							step_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_axis_tuser  <= res_status_q;
						m_axis_tlast  <= 1'b1;
						m_axis_tdata  <= {4'b0, res_vis_q, res_nm_q,
							to_out(pos_q[2*CW +: CW]),
							to_out(pos_q[CW +: CW]),
							to_out(pos_q[0 +: CW])};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "assert_macros.svh"

	`VNF_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
	`VNF_ASSERT_NEXT(a_add_grows, state_q == S_ADD && !full, count_q == $past(count_q) + 1'b1, "add did not grow the table")
	`VNF_ASSERT_NEXT(a_remove_shrinks, state_q == S_EVAL && req_q == REQ_REMOVE && found, count_q == $past(count_q) - 1'b1, "remove did not shrink the table")
	`VNF_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE || $past(state_q) == S_EMIT), "result raised outside a result state")

endmodule

// ----- bench/cull_result_checker.sv -----
// ----------------------------------------------------------------------------
// cull_result_checker
// Watches both streams of the voxel face culler and predicts every result.
// ----------------------------------------------------------------------------
// Each item accepted on s_axis is run through a local copy of the cube table.
// The results that the item should cause are queued in order. Each item
// accepted on m_axis is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module cull_result_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // out_x, out_y, out_z, neighbour_mask,
	                                    // visible_mask, zero
	input  logic [1:0]  m_axis_tuser,   // status[1:0]
	input  logic        m_axis_tlast,
	output int          failures,
	output int          outstanding
);
	import vnfc_pkg::*;

	typedef struct packed {
		status_t              status;
		logic [15:0]          x;
		logic [15:0]          y;
		logic [15:0]          z;
		logic [NUM_FACES-1:0] touching;
		logic [NUM_FACES-1:0] visible;
		logic                 last;
	} face_result_t;

	logic signed [15:0]   cube_x     [TABLE_DEPTH];
	logic signed [15:0]   cube_y     [TABLE_DEPTH];
	logic signed [15:0]   cube_z     [TABLE_DEPTH];
	logic [NUM_FACES-1:0] cube_faces [TABLE_DEPTH];
	int                   cube_count;
	face_result_t         expected_results [$];

	// Faces of a cell whose neighbor cell is occupied. The differences are
	// taken at full integer width, so the coordinate range never wraps.
	function automatic logic [NUM_FACES-1:0] occupied_faces(
		logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz);
		logic [NUM_FACES-1:0] faces;
		int dx, dy, dz;
		faces = '0;
		for (int i = 0; i < cube_count; i++) begin
			dx = int'(cube_x[i]) - int'(px);
			dy = int'(cube_y[i]) - int'(py);
			dz = int'(cube_z[i]) - int'(pz);
			if (dy == 0 && dz == 0) begin
				if (dx == 1)  faces[0] = 1'b1;
				if (dx == -1) faces[1] = 1'b1;
			end
			if (dx == 0 && dz == 0) begin
				if (dy == 1)  faces[2] = 1'b1;
				if (dy == -1) faces[3] = 1'b1;
			end
			if (dx == 0 && dy == 0) begin
				if (dz == 1)  faces[4] = 1'b1;
				if (dz == -1) faces[5] = 1'b1;
			end
		end
		return faces;
	endfunction

	function automatic void queue_result(status_t status, logic [15:0] x,
		logic [15:0] y, logic [15:0] z, logic [NUM_FACES-1:0] touching,
		logic [NUM_FACES-1:0] visible, logic last);
		face_result_t item;
		item = '{status, x, y, z, touching, visible, last};
		expected_results.insert(expected_results.size(), item);
	endfunction

	task automatic predict_request(req_t kind, logic signed [15:0] px,
		logic signed [15:0] py, logic signed [15:0] pz);
		logic [NUM_FACES-1:0] touching [TABLE_DEPTH];
		int hit;
		case (kind)
			REQ_ADD: begin
				if (cube_count >= TABLE_DEPTH) begin
					queue_result(ST_FULL, px, py, pz, '0, '0, 1'b1);
				end else begin
					cube_x[cube_count] = px;
					cube_y[cube_count] = py;
					cube_z[cube_count] = pz;
					cube_faces[cube_count] = ALL_FACES;
					cube_count++;
					queue_result(ST_OK, px, py, pz, '0, ALL_FACES, 1'b1);
				end
			end
			REQ_REMOVE: begin
				hit = -1;
				for (int i = 0; i < cube_count; i++) begin
					if (hit < 0 && cube_x[i] == px && cube_y[i] == py && cube_z[i] == pz)
						hit = i;
				end
				if (hit < 0) begin
					queue_result(ST_NOT_FOUND, px, py, pz, '0, '0, 1'b1);
				end else begin
					// Close the gap; the faces of the remaining cubes stay as they are.
					for (int i = hit; i < cube_count - 1; i++) begin
						cube_x[i] = cube_x[i+1];
						cube_y[i] = cube_y[i+1];
						cube_z[i] = cube_z[i+1];
						cube_faces[i] = cube_faces[i+1];
					end
					cube_count--;
					queue_result(ST_OK, px, py, pz, '0, '0, 1'b1);
				end
			end
			REQ_QUERY: begin
				queue_result(ST_OK, px, py, pz, occupied_faces(px, py, pz), '0, 1'b1);
			end
			REQ_CULL: begin
				if (cube_count == 0) begin
					queue_result(ST_EMPTY, '0, '0, '0, '0, '0, 1'b1);
				end else begin
					// All neighbor masks come from the table before any face is cleared.
					for (int i = 0; i < cube_count; i++)
						touching[i] = occupied_faces(cube_x[i], cube_y[i], cube_z[i]);
					for (int i = 0; i < cube_count; i++) begin
						cube_faces[i] = cube_faces[i] & ~touching[i];
						queue_result(ST_OK, cube_x[i], cube_y[i], cube_z[i], touching[i],
							cube_faces[i], i == cube_count - 1);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		face_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no expectation waiting: tdata 0x%h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 16'(want.status), 16'(m_axis_tuser));
					compare_field("out_x", want.x, m_axis_tdata[15:0]);
					compare_field("out_y", want.y, m_axis_tdata[31:16]);
					compare_field("out_z", want.z, m_axis_tdata[47:32]);
					compare_field("neighbour_mask", 16'(want.touching), 16'(m_axis_tdata[53:48]));
					compare_field("visible_mask", 16'(want.visible), 16'(m_axis_tdata[59:54]));
					compare_field("last", 16'(want.last), 16'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(req_t'(s_axis_tuser), s_axis_tdata[15:0],
					s_axis_tdata[31:16], s_axis_tdata[47:32]);
			outstanding = expected_results.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the voxel face culler.
// ----------------------------------------------------------------------------
// A short directed run covers the empty table, misses, coordinate extremes,
// duplicate cubes and face clearing. Four random phases follow, each with its
// own idling pattern on the two streams and its own mix of requests. Most
// positions fall in a 4x4x4 cluster so that neighbors, removal hits and a full
// table are common. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import vnfc_pkg::*;

	localparam int TABLE_DEPTH = 64;
	// A cull walks the chain twice; allow that much after the last result.
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;     // pos_x[15:0], pos_y[31:16], pos_z[47:32]
	logic [1:0]  s_axis_tuser = REQ_ADD; // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;          // out_x, out_y, out_z, neighbour_mask,
	                                    // visible_mask, zero
	logic [1:0]  m_axis_tuser;          // status[1:0]
	logic        m_axis_tlast;

	int failures;
	int outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold_cycles = 600;
	logic recv_hold_armed = 1'b0;
	int cluster_base = 0;

	voxel_neighbor_face_culler #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_BITS (16)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	cull_result_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) results_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver. Once armed, a hold-off stretch overrides the random stalls and
	// counts itself down here, one cycle per falling edge.
	always @(negedge clk) begin
		if (recv_hold_armed && recv_hold_cycles > 0) begin
			recv_hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Mostly inside the current cluster, sometimes a range extreme or anything.
	function automatic logic [15:0] random_coord();
		logic [15:0] extremes [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		int pick;
		pick = $urandom_range(99);
		if (pick < 88)
			return 16'(cluster_base + $urandom_range(3));
		if (pick < 94)
			return extremes[$urandom_range(3)];
		return 16'($urandom);
	endfunction

	// Offers one item and returns at the falling edge after it was taken, with
	// tvalid still high, so back-to-back items need no second assignment.
	task automatic send_item(req_t kind, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Random requests; whatever share is left after add, remove and query
	// goes to cull.
	task automatic run_phase(int count, int add_w, int remove_w, int query_w);
		int pick;
		req_t kind;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < add_w)
				kind = REQ_ADD;
			else if (pick < add_w + remove_w)
				kind = REQ_REMOVE;
			else if (pick < add_w + remove_w + query_w)
				kind = REQ_QUERY;
			else
				kind = REQ_CULL;
			send_item(kind, random_coord(), random_coord(), random_coord());
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty table: cull reports empty, remove misses, query sees nothing.
		send_item(REQ_CULL, 16'h0000, 16'h0000, 16'h0000);
		send_item(REQ_REMOVE, 16'h0003, 16'h0003, 16'h0003);
		send_item(REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
		// Both ends of the x range; they must not look adjacent across the wrap.
		send_item(REQ_ADD, 16'h7fff, 16'h0000, 16'h0000);
		send_item(REQ_ADD, 16'h8000, 16'h0000, 16'h0000);
		send_item(REQ_QUERY, 16'h7ffe, 16'h0000, 16'h0000);
		send_item(REQ_QUERY, 16'h7fff, 16'h0000, 16'h0000);
		send_item(REQ_QUERY, 16'h8001, 16'h0000, 16'h0000);
		// A small group around the origin, with a diagonal cube and a duplicate.
		send_item(REQ_ADD, 16'h0000, 16'h0000, 16'h0000);
		send_item(REQ_ADD, 16'h0001, 16'h0000, 16'h0000);
		send_item(REQ_ADD, 16'h0000, 16'hffff, 16'h0000);
		send_item(REQ_ADD, 16'h0000, 16'h0000, 16'h0001);
		send_item(REQ_ADD, 16'h0001, 16'h0001, 16'h0000);
		send_item(REQ_ADD, 16'h0000, 16'h0000, 16'h0000);
		// A cube at the queried position itself does not count.
		send_item(REQ_QUERY, 16'h0000, 16'h0000, 16'h0000);
		send_item(REQ_CULL, 16'h0000, 16'h0000, 16'h0000);
		// Removal takes the first copy; cleared faces stay cleared afterwards.
		send_item(REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000);
		send_item(REQ_REMOVE, 16'h0001, 16'h0000, 16'h0000);
		send_item(REQ_CULL, 16'h0000, 16'h0000, 16'h0000);
		// Alternating bit patterns on every coordinate.
		send_item(REQ_ADD, 16'h5555, 16'haaaa, 16'h0f0f);
		send_item(REQ_ADD, 16'haaaa, 16'h5555, 16'hf0f0);
		send_item(REQ_QUERY, 16'haaaa, 16'h5554, 16'hf0f0);
		send_item(REQ_REMOVE, 16'hffff, 16'hffff, 16'hffff);
		send_item(REQ_CULL, 16'h0000, 16'h0000, 16'h0000);

		// No idling; heavy on adds so the table fills and reports full.
		cluster_base = 0;
		run_phase(105, 70, 5, 15);

		// Sender idles often; heavy on removes so the table drains.
		send_idle_pct = 68;
		run_phase(105, 20, 50, 20);

		// Receiver stalls often, at the top of the coordinate range. Halfway
		// through it holds off for a long stretch while items keep coming.
		send_idle_pct = 0;
		recv_stall_pct = 68;
		cluster_base = 32764;
		run_phase(50, 45, 25, 20);
		recv_hold_armed = 1'b1;
		run_phase(55, 45, 25, 20);

		// Both sides idle, at the bottom of the range.
		send_idle_pct = 33;
		recv_stall_pct = 33;
		cluster_base = -32768;
		run_phase(105, 35, 35, 20);

		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog, far beyond a correct run even with every cull returning a full
	// table through the longest stalls.
	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/vnfc_pkg.sv
design/vnfc_cell.sv
design/voxel_neighbor_face_culler.sv
bench/cull_result_checker.sv
bench/testbench.sv
